// ----- hdl/atrp_pkg.sv -----
package atrp_pkg;

	// defaults for the top level parameters
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int ITER_DEF        = 16;

	// vector coordinates: samples scaled to about 2^39, gain and sqrt(2) growth below 2^43
	localparam int VEC_W     = 44;
	// angle accumulator in 1/65536 of a hundredth of a degree
	localparam int ACC_W     = 33;
	localparam int RND_W     = ACC_W - 16;
	localparam int ROLL_W    = 16;
	localparam int PITCH_W   = 15;
	localparam int TABLE_LEN = 24;
	localparam int IDX_W     = $clog2(TABLE_LEN);

	localparam logic signed [ACC_W-1:0] HALF_TURN = ACC_W'(64'sd1179648000);
	localparam logic signed [21:0]      GAIN_Q20  = 22'sd1726753;

	localparam logic signed [RND_W-1:0] ROLL_MAX  = RND_W'(18000);
	localparam logic signed [RND_W-1:0] PITCH_MAX = RND_W'(9000);

	typedef enum logic [1:0] {
		BASE_ZERO,
		BASE_POS,
		BASE_NEG
	} base_t;

	typedef struct packed {
		logic signed [VEC_W-1:0] x;
		logic signed [VEC_W-1:0] y;
		logic signed [ACC_W-1:0] acc;
		logic                    zero;
	} rot_t;

	typedef struct packed {
		logic signed [VEC_W-1:0] py;
		base_t                   base;
	} roll_side_t;

	typedef struct packed {
		logic signed [ROLL_W-1:0] roll;
	} pitch_side_t;

	// atan(2^-i) in accumulator units
	function automatic logic signed [ACC_W-1:0] atan_entry(input logic [IDX_W-1:0] idx);
		logic signed [ACC_W-1:0] v;
		case (idx)
			5'd0:    v = ACC_W'(64'sd294912000);
			5'd1:    v = ACC_W'(64'sd174096719);
			5'd2:    v = ACC_W'(64'sd91987925);
			5'd3:    v = ACC_W'(64'sd46694507);
			5'd4:    v = ACC_W'(64'sd23437865);
			5'd5:    v = ACC_W'(64'sd11730358);
			5'd6:    v = ACC_W'(64'sd5866610);
			5'd7:    v = ACC_W'(64'sd2933484);
			5'd8:    v = ACC_W'(64'sd1466764);
			5'd9:    v = ACC_W'(64'sd733385);
			5'd10:   v = ACC_W'(64'sd366693);
			5'd11:   v = ACC_W'(64'sd183346);
			5'd12:   v = ACC_W'(64'sd91673);
			5'd13:   v = ACC_W'(64'sd45837);
			5'd14:   v = ACC_W'(64'sd22918);
			5'd15:   v = ACC_W'(64'sd11459);
			5'd16:   v = ACC_W'(64'sd5730);
			5'd17:   v = ACC_W'(64'sd2865);
			5'd18:   v = ACC_W'(64'sd1432);
			5'd19:   v = ACC_W'(64'sd716);
			5'd20:   v = ACC_W'(64'sd358);
			5'd21:   v = ACC_W'(64'sd179);
			5'd22:   v = ACC_W'(64'sd90);
			5'd23:   v = ACC_W'(64'sd45);
			default: v = '0;
		endcase
		return v;
	endfunction

	// round to nearest hundredth, halves toward plus infinity
	function automatic logic signed [RND_W-1:0] round_units(input logic signed [ACC_W-1:0] a);
		logic signed [ACC_W-1:0] s;
		s = a + ACC_W'(32768);
		return s[ACC_W-1:16];
	endfunction

endpackage

// ----- hdl/atrp_prep.sv -----
module atrp_prep
	import atrp_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	output logic               vld,
	output rot_t               rot,
	output roll_side_t         side
);

	localparam int GUARD = 40 - SAMPLE_BITS;
	localparam int IW    = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;
	localparam int LSH   = (GUARD >= 20) ? GUARD - 20 : 0;
	localparam int RSH   = (GUARD >= 20) ? 0 : 20 - GUARD;
	localparam int PW    = SAMPLE_BITS + 23;

	logic [IW-1:0]                raw_x, raw_y, raw_z;
	logic signed [SAMPLE_BITS-1:0] sx, sy, sz;
	logic signed [SAMPLE_BITS:0]   nx;
	logic signed [PW-1:0]          prod, prod_sh;
	logic signed [VEC_W-1:0]       vz, vy, py;
	rot_t                          rot_d;
	roll_side_t                    side_d;
	logic                          vld_s1;
	rot_t                          rot_s1;
	roll_side_t                    side_s1;

	// bits above the sample width are ignored
	assign raw_x = IW'($unsigned(accel_x));
	assign raw_y = IW'($unsigned(accel_y));
	assign raw_z = IW'($unsigned(accel_z));
	assign sx    = raw_x[SAMPLE_BITS-1:0];
	assign sy    = raw_y[SAMPLE_BITS-1:0];
	assign sz    = raw_z[SAMPLE_BITS-1:0];

	assign vz = VEC_W'(sz) <<< GUARD;
	assign vy = VEC_W'(sy) <<< GUARD;

	// pitch y: -x scaled by the vectoring gain
	assign nx      = -((SAMPLE_BITS + 1)'(sx));
	assign prod    = PW'(nx) * PW'(GAIN_Q20);
	assign prod_sh = prod >>> RSH;
	assign py      = VEC_W'(prod_sh) <<< LSH;

	always_comb begin
		rot_d.acc   = '0;
		rot_d.zero  = (sy == '0);
		side_d.py   = py;
		if (sz[SAMPLE_BITS-1]) begin
			// fold into the right half plane
			rot_d.x     = -vz;
			rot_d.y     = -vy;
			side_d.base = sy[SAMPLE_BITS-1] ? BASE_NEG : BASE_POS;
		end else begin
			rot_d.x     = vz;
			rot_d.y     = vy;
			side_d.base = BASE_ZERO;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rot_s1  <= rot_d;
			side_s1 <= side_d;
		end
	end

	assign vld  = vld_s1;
	assign rot  = rot_s1;
	assign side = side_s1;

endmodule

// ----- hdl/atrp_stage.sv -----
module atrp_stage
	import atrp_pkg::*;
#(
	parameter int  SHIFT  = 0,
	parameter type SIDE_T = roll_side_t
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  in_vld,
	input  rot_t  in_rot,
	input  SIDE_T in_side,
	output logic  out_vld,
	output rot_t  out_rot,
	output SIDE_T out_side
);

	localparam logic signed [ACC_W-1:0] STEP = atan_entry(IDX_W'(SHIFT));

	logic signed [VEC_W-1:0] dx, dy;
	rot_t                    rot_d;
	logic                    vld_s1;
	rot_t                    rot_s1;
	SIDE_T                   side_s1;

	assign dx = in_rot.y >>> SHIFT;
	assign dy = in_rot.x >>> SHIFT;

	always_comb begin
		rot_d.zero = in_rot.zero;
		if (!in_rot.y[VEC_W-1]) begin
			rot_d.x   = in_rot.x + dx;
			rot_d.y   = in_rot.y - dy;
			rot_d.acc = in_rot.acc + STEP;
		end else begin
			rot_d.x   = in_rot.x - dx;
			rot_d.y   = in_rot.y + dy;
			rot_d.acc = in_rot.acc - STEP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rot_s1  <= rot_d;
			side_s1 <= in_side;
		end
	end

	assign out_vld  = vld_s1;
	assign out_rot  = rot_s1;
	assign out_side = side_s1;

endmodule

// ----- hdl/atrp_link.sv -----
module atrp_link
	import atrp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_vld,
	input  rot_t        in_rot,
	input  roll_side_t  in_side,
	output logic        out_vld,
	output rot_t        out_rot,
	output pitch_side_t out_side
);

	logic signed [ACC_W-1:0] base_val, resid, roll_sum;
	logic signed [RND_W-1:0] roll_rnd;
	rot_t                    rot_d;
	pitch_side_t             side_d;
	logic                    vld_s1;
	rot_t                    rot_s1;
	pitch_side_t             side_s1;

	always_comb begin
		case (in_side.base)
			BASE_POS: base_val = HALF_TURN;
			BASE_NEG: base_val = -HALF_TURN;
			default:  base_val = '0;
		endcase
	end

	// vector already on the axis adds no residual angle
	assign resid    = in_rot.zero ? '0 : in_rot.acc;
	assign roll_sum = base_val + resid;
	assign roll_rnd = round_units(roll_sum);

	always_comb begin
		// plus or minus half turn and beyond fold onto plus half turn
		if (roll_rnd >= ROLL_MAX || roll_rnd <= -ROLL_MAX) begin
			side_d.roll = ROLL_W'(ROLL_MAX);
		end else begin
			side_d.roll = ROLL_W'(roll_rnd);
		end
		rot_d.x    = in_rot.x;
		rot_d.y    = in_side.py;
		rot_d.acc  = '0;
		rot_d.zero = (in_side.py == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rot_s1  <= rot_d;
			side_s1 <= side_d;
		end
	end

	assign out_vld  = vld_s1;
	assign out_rot  = rot_s1;
	assign out_side = side_s1;

endmodule

// ----- hdl/atrp_out.sv -----
module atrp_out
	import atrp_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_vld,
	input  rot_t                      in_rot,
	input  pitch_side_t               in_side,
	output logic                      out_valid,
	output logic signed [ROLL_W-1:0]  roll_angle,
	output logic signed [PITCH_W-1:0] pitch_angle
);

	logic signed [ACC_W-1:0]   resid;
	logic signed [RND_W-1:0]   pitch_rnd;
	logic signed [PITCH_W-1:0] pitch_d;
	logic                      vld_s1;
	logic signed [ROLL_W-1:0]  roll_s1;
	logic signed [PITCH_W-1:0] pitch_s1;

	assign resid     = in_rot.zero ? '0 : in_rot.acc;
	assign pitch_rnd = round_units(resid);

	always_comb begin
		if (pitch_rnd > PITCH_MAX) begin
			pitch_d = PITCH_W'(PITCH_MAX);
		end else if (pitch_rnd < -PITCH_MAX) begin
			pitch_d = PITCH_W'(-PITCH_MAX);
		end else begin
			pitch_d = PITCH_W'(pitch_rnd);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			roll_s1  <= in_side.roll;
			pitch_s1 <= pitch_d;
		end
	end

	assign out_valid   = vld_s1;
	assign roll_angle  = roll_s1;
	assign pitch_angle = pitch_s1;

endmodule

// ----- hdl/accel_tilt_roll_pitch.sv -----
// channel   direction  handshake             payload
// sample    in         in_valid / in_ready   accel_x, accel_y, accel_z (16 b signed each)
// angles    out        out_valid / out_ready roll_angle (16 b), pitch_angle (15 b signed)
//
// one sample per cycle while the pipeline is not stalled; one vectoring rotation per register
//   stage, for roll and then for pitch
// reset clears only the valid bits of every stage, no clearing pass
// one stall signal freezes the whole pipeline while the output register holds an
//   untaken transaction; bubbles are not squeezed out during a stall
module accel_tilt_roll_pitch
	import atrp_pkg::*;
#(
	parameter int SAMPLE_BITS      = SAMPLE_BITS_DEF,
	parameter int ANGLE_ITERATIONS = ITER_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [15:0]        accel_x,
	input  logic signed [15:0]        accel_y,
	input  logic signed [15:0]        accel_z,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [ROLL_W-1:0]  roll_angle,
	output logic signed [PITCH_W-1:0] pitch_angle
);

	localparam int N = ANGLE_ITERATIONS;

	// pipeline advances whenever the output register is empty or being drained
	logic en;

	// roll chain: index 0 is the entry stage, index k+1 follows rotation k
	logic        roll_vld  [0:N];
	rot_t        roll_rot  [0:N];
	roll_side_t  roll_side [0:N];

	// pitch chain: index 0 is the hand-over stage
	logic        pitch_vld  [0:N];
	rot_t        pitch_rot  [0:N];
	pitch_side_t pitch_side [0:N];

	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// sign extension, half-plane fold and the gain multiply for the pitch y
	atrp_prep #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.accel_x  (accel_x),
		.accel_y  (accel_y),
		.accel_z  (accel_z),
		.vld      (roll_vld[0]),
		.rot      (roll_rot[0]),
		.side     (roll_side[0])
	);

	// roll vectoring, one micro-rotation per stage
	for (genvar k = 0; k < N; k++) begin : g_roll
		atrp_stage #(
			.SHIFT  (k),
			.SIDE_T (roll_side_t)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_vld   (roll_vld[k]),
			.in_rot   (roll_rot[k]),
			.in_side  (roll_side[k]),
			.out_vld  (roll_vld[k+1]),
			.out_rot  (roll_rot[k+1]),
			.out_side (roll_side[k+1])
		);
	end

	// roll is finished here; its final x (scaled magnitude) seeds the pitch vector
	atrp_link u_link (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (roll_vld[N]),
		.in_rot   (roll_rot[N]),
		.in_side  (roll_side[N]),
		.out_vld  (pitch_vld[0]),
		.out_rot  (pitch_rot[0]),
		.out_side (pitch_side[0])
	);

	// pitch vectoring, roll result rides along
	for (genvar k = 0; k < N; k++) begin : g_pitch
		atrp_stage #(
			.SHIFT  (k),
			.SIDE_T (pitch_side_t)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_vld   (pitch_vld[k]),
			.in_rot   (pitch_rot[k]),
			.in_side  (pitch_side[k]),
			.out_vld  (pitch_vld[k+1]),
			.out_rot  (pitch_rot[k+1]),
			.out_side (pitch_side[k+1])
		);
	end

	// pitch rounding and clamp into the output register
	atrp_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_vld      (pitch_vld[N]),
		.in_rot      (pitch_rot[N]),
		.in_side     (pitch_side[N]),
		.out_valid   (out_valid),
		.roll_angle  (roll_angle),
		.pitch_angle (pitch_angle)
	);

endmodule

// ----- hdl/atrp_checker.sv -----
module atrp_checker
	import atrp_pkg::*;
(
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic signed [15:0]        accel_x,
	input logic signed [15:0]        accel_y,
	input logic signed [15:0]        accel_z,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic signed [ROLL_W-1:0]  roll_angle,
	input logic signed [PITCH_W-1:0] pitch_angle
);

	// a held result blocks new transactions
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while output stalled");

	// a waiting sample keeps its payload
	a_in_holds: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(accel_x) && $stable(accel_y)
			&& $stable(accel_z))
		else $error("waiting sample changed");

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(roll_angle) && $stable(pitch_angle))
		else $error("stalled result changed");

	// minus half turn never shows
	a_roll_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> roll_angle <= 16'sd18000 && roll_angle > -16'sd18000)
		else $error("roll out of range");

	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pitch_angle <= 15'sd9000 && pitch_angle >= -15'sd9000)
		else $error("pitch out of range");

endmodule

bind accel_tilt_roll_pitch atrp_checker u_atrp_checker (.*);
